// ===== hw/rtl/ddsm_pkg.sv =====
// Shared types and constants for the differential-drive slew mixer.
// Holds field widths, register map, controller states and the
// command/status structs that join the controller and the datapath.
`timescale 1ns / 1ps

package ddsm_pkg;

    // Field and internal widths
    localparam int VEL_W      = 16;   // Q4.12 velocities
    localparam int CMD_W      = 16;   // Q1.14 motor commands
    localparam int LIM_W      = 15;   // speed limits and steps
    localparam int SEP_W      = 16;   // Q0.16 wheel separation
    localparam int TICK_W     = 16;   // watchdog count
    localparam int SIDE_W     = 18;   // velocity sums and differences
    localparam int PROD_W     = 33;   // signed angular velocity times separation
    localparam int HALF_SHIFT = 17;   // halve and rescale Q4.28 to Q4.12
    localparam int MAG_W      = 15;   // normalized magnitude, 0..16384
    localparam int REM_W      = 16;   // divider partial remainder
    localparam int DIV_STEPS  = 15;   // one quotient bit per step
    localparam int CNT_W      = 4;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [MAG_W-1:0]  Q14_ONE   = MAG_W'(16384);
    localparam logic [PROD_W-1:0] HALF_BIAS = PROD_W'((64'd1 << HALF_SHIFT) - 64'd1);
    localparam logic [TICK_W-1:0] TICK_MAX  = '1;

    // Input opcodes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Register indexes, at byte address 4*index
    typedef enum logic [2:0] {
        REG_MAX_LIN       = 3'd0,
        REG_MAX_ANG       = 3'd1,
        REG_WHEEL_SEP     = 3'd2,
        REG_TIMEOUT_TICKS = 3'd3,
        REG_LIN_STEP      = 3'd4,
        REG_ANG_STEP      = 3'd5,
        REG_LEFT_INVERT   = 3'd6,
        REG_RIGHT_INVERT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [LIM_W-1:0]  max_lin;
        logic [LIM_W-1:0]  max_ang;
        logic [SEP_W-1:0]  wheel_sep;
        logic [TICK_W-1:0] timeout_ticks;
        logic [LIM_W-1:0]  lin_step;
        logic [LIM_W-1:0]  ang_step;
        logic              left_invert;
        logic              right_invert;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_lin:       LIM_W'(1638),
        max_ang:       LIM_W'(12288),
        wheel_sep:     SEP_W'(6554),
        timeout_ticks: TICK_W'(25),
        lin_step:      LIM_W'(82),
        ang_step:      LIM_W'(492),
        left_invert:   1'b0,
        right_invert:  1'b0
    };

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WDOG,
        ST_SLEW,
        ST_MULT,
        ST_SIDE,
        ST_LSTART,
        ST_LRUN,
        ST_RSTART,
        ST_RRUN,
        ST_OUT,
        ST_STOP_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // take targets from a command beat
        logic tick;       // advance the watchdog count
        logic clear_vel;  // watchdog stop: zero both velocities
        logic req_load;   // clamp targets to the limits
        logic slew;       // step current velocities toward the targets
        logic mult;       // angular velocity times separation
        logic side;       // form both wheel speeds
        logic div_start;  // start a normalization
        logic div_right;  // divider source is the right side
        logic hold_left;  // keep the finished left command
        logic out_load;   // write the output register
        logic out_stop;   // output is a watchdog stop
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic expired;
        logic div_busy;
    } dp_sts_t;

endpackage

// ===== hw/rtl/diff_drive_slew_mixer_core.sv =====
// Top level of the differential-drive slew mixer.
// Depends on ddsm_pkg, ddsm_regs, ddsm_ctrl and ddsm_dp.
//
// Usage:
//   Input channel (in_valid/in_stall): opcode 0 is a velocity command that
//   latches target_lin/target_ang and restarts the watchdog; it gives no
//   result. Opcode 1 is a control tick that gives
//   exactly one output beat (left_cmd, right_cmd, stopped).
//   A normal tick runs two 15-step bit-serial normalizations, left then
//   right, on one shared divider; a watchdog stop skips them.
//   No new beat is taken until the current tick is through.
//   in_stall is high whenever the controller is busy with a tick.
//   Output channel (out_valid/out_stall): a result sits in an output
//   register; while the receiver stalls it holds, the next tick is still
//   accepted and computed, and its result waits in the controller until
//   the register frees up.
//   Configuration is written through the APB-style port (register i at
//   byte address 4*i) while the block is idle; pready is tied high.
//   Reset (rst_n, asynchronous, active low) restores the default limits,
//   zeroes all velocities and the watchdog count, and empties the output.
`timescale 1ns / 1ps

module diff_drive_slew_mixer_core
    import ddsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    opcode,
    input  logic signed [VEL_W-1:0] target_lin,
    input  logic signed [VEL_W-1:0] target_ang,
    // Output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [CMD_W-1:0] left_cmd,
    output logic signed [CMD_W-1:0] right_cmd,
    output logic                    stopped,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // Configuration registers
    ddsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    ddsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and state
    ddsm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .target_lin (target_lin),
        .target_ang (target_ang),
        .left_cmd   (left_cmd),
        .right_cmd  (right_cmd),
        .stopped    (stopped)
    );

endmodule

// ===== hw/rtl/ddsm_regs.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on ddsm_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps

module ddsm_regs
    import ddsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_LIN:       cfg_next.max_lin       = pwdata[LIM_W-1:0];
                REG_MAX_ANG:       cfg_next.max_ang       = pwdata[LIM_W-1:0];
                REG_WHEEL_SEP:     cfg_next.wheel_sep     = pwdata[SEP_W-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[TICK_W-1:0];
                REG_LIN_STEP:      cfg_next.lin_step      = pwdata[LIM_W-1:0];
                REG_ANG_STEP:      cfg_next.ang_step      = pwdata[LIM_W-1:0];
                REG_LEFT_INVERT:   cfg_next.left_invert   = pwdata[0];
                REG_RIGHT_INVERT:  cfg_next.right_invert  = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (idx)
            REG_MAX_LIN:       prdata = DATA_W'(cfg_reg.max_lin);
            REG_MAX_ANG:       prdata = DATA_W'(cfg_reg.max_ang);
            REG_WHEEL_SEP:     prdata = DATA_W'(cfg_reg.wheel_sep);
            REG_TIMEOUT_TICKS: prdata = DATA_W'(cfg_reg.timeout_ticks);
            REG_LIN_STEP:      prdata = DATA_W'(cfg_reg.lin_step);
            REG_ANG_STEP:      prdata = DATA_W'(cfg_reg.ang_step);
            REG_LEFT_INVERT:   prdata = DATA_W'(cfg_reg.left_invert);
            REG_RIGHT_INVERT:  prdata = DATA_W'(cfg_reg.right_invert);
        endcase
    end

endmodule

// ===== hw/rtl/ddsm_dp.sv =====
// Datapath: velocity state, watchdog count, slew limiter, mixer,
// shared bit-serial normalizing divider and the output register.
// Depends on ddsm_pkg; driven by ddsm_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module ddsm_dp
    import ddsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    input  logic signed [VEL_W-1:0] target_lin,
    input  logic signed [VEL_W-1:0] target_ang,
    output logic signed [CMD_W-1:0] left_cmd,
    output logic signed [CMD_W-1:0] right_cmd,
    output logic                    stopped
);

    // Clamp x to the range -lim..lim
    function automatic logic signed [SIDE_W-1:0] clamp_sym(
        input logic signed [SIDE_W-1:0] x,
        input logic [LIM_W-1:0]         lim
    );
        logic signed [SIDE_W-1:0] hi;
        logic signed [SIDE_W-1:0] lo;
        logic signed [SIDE_W-1:0] res;
        hi = $signed(SIDE_W'(lim));
        lo = -hi;
        if (x < lo)
            res = lo;
        else if (x > hi)
            res = hi;
        else
            res = x;
        return res;
    endfunction

    // Two's complement of a magnitude when flip is set
    function automatic logic [CMD_W-1:0] apply_sign(
        input logic [MAG_W-1:0] mag,
        input logic             flip
    );
        logic [CMD_W-1:0] wide;
        wide = CMD_W'(mag);
        return flip ? (~wide + CMD_W'(1)) : wide;
    endfunction

    // Persistent state
    logic signed [VEL_W-1:0] latched_lin_reg;
    logic signed [VEL_W-1:0] latched_ang_reg;
    logic signed [VEL_W-1:0] cur_lin_reg;
    logic signed [VEL_W-1:0] cur_ang_reg;
    logic [TICK_W-1:0]       ticks_reg;

    // Per-tick working registers
    logic signed [VEL_W-1:0]  req_lin_reg;
    logic signed [VEL_W-1:0]  req_ang_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SIDE_W-1:0] side_l_reg;
    logic signed [SIDE_W-1:0] side_r_reg;
    logic [CMD_W-1:0]         left_res_reg;

    // Divider
    logic [REM_W-1:0] rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             sat_reg;
    logic             zero_reg;

    // Output register
    logic [CMD_W-1:0] left_cmd_reg;
    logic [CMD_W-1:0] right_cmd_reg;
    logic             stopped_reg;

    logic signed [SIDE_W-1:0] lin_req_c;
    logic signed [SIDE_W-1:0] ang_req_c;
    logic signed [SIDE_W-1:0] lin_diff;
    logic signed [SIDE_W-1:0] ang_diff;
    logic signed [SIDE_W-1:0] lin_new;
    logic signed [SIDE_W-1:0] ang_new;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [VEL_W-1:0]  half;
    logic signed [SIDE_W-1:0] div_src;
    logic [SIDE_W-1:0]        div_src_mag;
    logic                     div_ge;
    logic [REM_W-1:0]         div_sub;
    logic [REM_W-1:0]         max_lin_w;
    logic [MAG_W-1:0]         div_mag;

    assign sts.expired  = ticks_reg > cfg.timeout_ticks;
    assign sts.div_busy = cnt_reg != '0;

    // Clamp targets and step toward them
    assign lin_req_c = clamp_sym(SIDE_W'(latched_lin_reg), cfg.max_lin);
    assign ang_req_c = clamp_sym(SIDE_W'(latched_ang_reg), cfg.max_ang);
    assign lin_diff  = SIDE_W'(req_lin_reg) - SIDE_W'(cur_lin_reg);
    assign ang_diff  = SIDE_W'(req_ang_reg) - SIDE_W'(cur_ang_reg);
    assign lin_new   = SIDE_W'(cur_lin_reg) + clamp_sym(lin_diff, cfg.lin_step);
    assign ang_new   = SIDE_W'(cur_ang_reg) + clamp_sym(ang_diff, cfg.ang_step);

    // Half of w*sep, truncated toward zero
    assign prod_adj = prod_reg + (prod_reg[PROD_W-1] ? $signed(HALF_BIAS) : $signed(PROD_W'(0)));
    assign half     = prod_adj[HALF_SHIFT+VEL_W-1:HALF_SHIFT];

    // Divider source and one restoring step
    assign div_src     = cmd.div_right ? side_r_reg : side_l_reg;
    assign div_src_mag = div_src[SIDE_W-1] ? SIDE_W'(-div_src) : SIDE_W'(div_src);
    assign max_lin_w   = REM_W'(cfg.max_lin);
    assign div_ge      = rem_reg >= max_lin_w;
    assign div_sub     = div_ge ? (rem_reg - max_lin_w) : rem_reg;
    assign div_mag     = zero_reg ? '0 : (sat_reg ? Q14_ONE : quo_reg);

    // Persistent state and watchdog
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_lin_reg <= '0;
            latched_ang_reg <= '0;
            cur_lin_reg     <= '0;
            cur_ang_reg     <= '0;
            ticks_reg       <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                latched_lin_reg <= target_lin;
                latched_ang_reg <= target_ang;
                ticks_reg       <= '0;
            end
            else if (cmd.tick && ticks_reg != TICK_MAX)
            begin
                ticks_reg <= ticks_reg + TICK_W'(1);
            end

            if (cmd.clear_vel)
            begin
                cur_lin_reg <= '0;
                cur_ang_reg <= '0;
            end
            else if (cmd.slew)
            begin
                cur_lin_reg <= lin_new[VEL_W-1:0];
                cur_ang_reg <= ang_new[VEL_W-1:0];
            end
        end
    end

    // Mixer working registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_lin_reg <= lin_req_c[VEL_W-1:0];
            req_ang_reg <= ang_req_c[VEL_W-1:0];
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(cur_ang_reg) * PROD_W'($signed({1'b0, cfg.wheel_sep}));
        end
        if (cmd.side)
        begin
            side_l_reg <= SIDE_W'(cur_lin_reg) - SIDE_W'(half);
            side_r_reg <= SIDE_W'(cur_lin_reg) + SIDE_W'(half);
        end
        if (cmd.hold_left)
        begin
            left_res_reg <= apply_sign(div_mag, neg_reg ^ cfg.left_invert);
        end
    end

    // Divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(DIV_STEPS);
        end
        else if (sts.div_busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Divider: load magnitude, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= div_src_mag[REM_W-1:0];
            quo_reg  <= '0;
            neg_reg  <= div_src[SIDE_W-1];
            sat_reg  <= div_src_mag > SIDE_W'(cfg.max_lin);
            zero_reg <= cfg.max_lin == '0;
        end
        else if (sts.div_busy)
        begin
            rem_reg <= {div_sub[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[MAG_W-2:0], div_ge};
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_cmd_reg  <= cmd.out_stop ? '0 : left_res_reg;
            right_cmd_reg <= cmd.out_stop ? '0 : apply_sign(div_mag, neg_reg ^ cfg.right_invert);
            stopped_reg   <= cmd.out_stop;
        end
    end

    assign left_cmd  = left_cmd_reg;
    assign right_cmd = right_cmd_reg;
    assign stopped   = stopped_reg;

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cnt_reg) == CNT_W'(1) && !$past(cmd.div_start) |-> div_mag <= Q14_ONE)
        else $error("normalized magnitude above one");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_vel |=> cur_lin_reg == '0 && cur_ang_reg == '0)
        else $error("velocities not cleared on watchdog stop");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick && !cmd.latch |=> ticks_reg != '0)
        else $error("watchdog count did not advance");

endmodule

// ===== hw/rtl/ddsm_ctrl.sv =====
// Controller state machine: sequences watchdog, slew, mix and the two
// normalizations, and owns the input stall and the output valid.
// Depends on ddsm_pkg for state_t, dp_cmd_t and dp_sts_t.
`timescale 1ns / 1ps

module ddsm_ctrl
    import ddsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    opcode,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_accept;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // Drop the output beat once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = ST_WDOG;
                    end
                    else
                    begin
                        cmd.latch = 1'b1;
                    end
                end
            end
            ST_WDOG:
            begin
                if (sts.expired)
                begin
                    cmd.clear_vel = 1'b1;
                    state_next    = ST_STOP_OUT;
                end
                else
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_SIDE;
            end
            ST_SIDE:
            begin
                cmd.side   = 1'b1;
                state_next = ST_LSTART;
            end
            ST_LSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_LRUN;
            end
            ST_LRUN:
            begin
                if (!sts.div_busy)
                    state_next = ST_RSTART;
            end
            ST_RSTART:
            begin
                cmd.hold_left = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_right = 1'b1;
                state_next    = ST_RRUN;
            end
            ST_RRUN:
            begin
                if (!sts.div_busy)
                    state_next = ST_OUT;
            end
            ST_OUT, ST_STOP_OUT:
            begin
                // Load when the output slot is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_stop   = state_reg == ST_STOP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || !out_stall)
        else $error("pending output beat overwritten");

    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    a_div_done_at_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> !sts.div_busy && $past(state_reg) != ST_IDLE)
        else $error("result emitted before normalization finished");

endmodule

// ===== dv/ddsm_checker.sv =====
// Scoreboard for the differential-drive slew mixer: watches both channels
// and the register port, predicts each tick's motor commands and compares.
// Depends on ddsm_pkg for widths, register indexes and the register struct.
`timescale 1ns / 1ps

module ddsm_checker
    import ddsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    opcode,
    input  logic signed [VEL_W-1:0] target_lin,
    input  logic signed [VEL_W-1:0] target_ang,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [CMD_W-1:0] left_cmd,
    input  logic signed [CMD_W-1:0] right_cmd,
    input  logic                    stopped,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output int                      fail_count,
    output int                      pending_count
);

    localparam int CMD_UNIT  = 1 << (CMD_W - 2);   // 1.0 in Q1.14
    localparam int HALF_DIV  = 1 << HALF_SHIFT;

    typedef struct packed {
        logic signed [CMD_W-1:0] left_cmd;
        logic signed [CMD_W-1:0] right_cmd;
        logic                    stopped;
    } drive_beat_t;

    // Shadow of the block's registers and motion state
    cfg_t                    setup;
    logic signed [VEL_W-1:0] goal_lin;
    logic signed [VEL_W-1:0] goal_ang;
    logic signed [VEL_W-1:0] speed_lin;
    logic signed [VEL_W-1:0] speed_ang;
    logic [TICK_W-1:0]       idle_ticks;
    drive_beat_t             drive_q[$];
    int                      beat_no;

    function automatic int clamp_to(int x, int lim);
        if (x < -lim) return -lim;
        if (x > lim) return lim;
        return x;
    endfunction

    function automatic logic signed [VEL_W-1:0] slew_to(logic signed [VEL_W-1:0] cur,
                                                        int goal, int step_lim);
        int now_v;
        now_v = cur;
        return VEL_W'(now_v + clamp_to(goal - now_v, step_lim));
    endfunction

    // Scale one wheel speed to Q1.14, saturate, then apply the side's inversion
    function automatic logic signed [CMD_W-1:0] scale_side(int side, logic invert);
        longint q;
        int     scale;
        scale = setup.max_lin;
        if (scale == 0)
            q = 0;
        else
            q = (longint'(side) * CMD_UNIT) / scale;
        if (q > CMD_UNIT) q = CMD_UNIT;
        if (q < -CMD_UNIT) q = -CMD_UNIT;
        if (invert) q = -q;
        return CMD_W'(q);
    endfunction

    // Advance the watchdog and the slew state by one tick; return its beat
    function automatic drive_beat_t advance_tick();
        drive_beat_t b;
        int          lin_goal;
        int          ang_goal;
        int          ang_now;
        int          sep;
        int          half;
        int          lin_now;
        if (idle_ticks != TICK_MAX) idle_ticks++;
        if (idle_ticks > setup.timeout_ticks) begin
            speed_lin   = '0;
            speed_ang   = '0;
            b.left_cmd  = '0;
            b.right_cmd = '0;
            b.stopped   = 1'b1;
            return b;
        end
        lin_goal  = clamp_to(goal_lin, setup.max_lin);
        ang_goal  = clamp_to(goal_ang, setup.max_ang);
        speed_lin = slew_to(speed_lin, lin_goal, setup.lin_step);
        speed_ang = slew_to(speed_ang, ang_goal, setup.ang_step);
        ang_now   = speed_ang;
        sep       = setup.wheel_sep;
        lin_now   = speed_lin;
        half      = int'((longint'(ang_now) * sep) / HALF_DIV);
        b.left_cmd  = scale_side(lin_now - half, setup.left_invert);
        b.right_cmd = scale_side(lin_now + half, setup.right_invert);
        b.stopped   = 1'b0;
        return b;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        case (reg_idx_t'(addr[ADDR_W-1:2]))
            REG_MAX_LIN:       setup.max_lin       = data[LIM_W-1:0];
            REG_MAX_ANG:       setup.max_ang       = data[LIM_W-1:0];
            REG_WHEEL_SEP:     setup.wheel_sep     = data[SEP_W-1:0];
            REG_TIMEOUT_TICKS: setup.timeout_ticks = data[TICK_W-1:0];
            REG_LIN_STEP:      setup.lin_step      = data[LIM_W-1:0];
            REG_ANG_STEP:      setup.ang_step      = data[LIM_W-1:0];
            REG_LEFT_INVERT:   setup.left_invert   = data[0];
            REG_RIGHT_INVERT:  setup.right_invert  = data[0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR: beat %0d: %s", beat_no, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        drive_beat_t want;
        if (!rst_n) begin
            setup         = CFG_RESET;
            goal_lin      = '0;
            goal_ang      = '0;
            speed_lin     = '0;
            speed_ang     = '0;
            idle_ticks    = '0;
            beat_no       = 0;
            fail_count    = 0;
            pending_count = 0;
            drive_q.delete();
        end
        else begin
            // Check the output beat against the oldest pending tick
            if (out_valid && !out_stall) begin
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("output beat with no tick pending (%0d %0d %0d)",
                                              left_cmd, right_cmd, stopped));
                end
                else begin
                    want = drive_q.pop_front();
                    if (left_cmd !== want.left_cmd)
                        report_mismatch($sformatf("left_cmd got %0d expected %0d",
                                                  left_cmd, want.left_cmd));
                    if (right_cmd !== want.right_cmd)
                        report_mismatch($sformatf("right_cmd got %0d expected %0d",
                                                  right_cmd, want.right_cmd));
                    if (stopped !== want.stopped)
                        report_mismatch($sformatf("stopped got %0b expected %0b",
                                                  stopped, want.stopped));
                end
                beat_no++;
            end
            // Track register writes
            if (psel && penable && pwrite && pready)
                write_reg(paddr, pwdata);
            // Latch a command or predict a tick
            if (in_valid && !in_stall) begin
                if (opcode == OP_COMMAND) begin
                    goal_lin   = target_lin;
                    goal_ang   = target_ang;
                    idle_ticks = '0;
                end
                else begin
                    drive_q.push_back(advance_tick());
                end
            end
            pending_count = drive_q.size();
        end
    end

endmodule

// ===== dv/tb_diff_drive_slew_mixer_core.sv =====
// Top-level testbench for diff_drive_slew_mixer_core: resets the block,
// drives register settings and command/tick beats, and gives the verdict.
// Depends on ddsm_pkg, the block's RTL and ddsm_checker.
`timescale 1ns / 1ps

module tb_diff_drive_slew_mixer_core
    import ddsm_pkg::*;
();

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 50;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 115;
    localparam int RANDOM_PHASES = 6;
    localparam int COMMAND_PCT   = 20;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic signed [VEL_W-1:0] target_lin;
    logic signed [VEL_W-1:0] target_ang;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [CMD_W-1:0] left_cmd;
    logic signed [CMD_W-1:0] right_cmd;
    logic                    stopped;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int fail_count;
    int pending_count;
    int quiet_cycles;
    bit sender_gaps;
    bit receiver_gaps;
    bit hold_req;

    diff_drive_slew_mixer_core i_dut (.*);

    ddsm_checker i_checker (.*);

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Abort when no beat or register access moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stall before each beat, one long hold on request
    initial
    begin
        int pause;
        bit held;
        out_stall = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pause = receiver_gaps ? $urandom_range(0, 3) : 0;
            if (hold_req && !held)
            begin
                pause = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (pause > 0)
            begin
                out_stall = 1'b1;
                repeat (pause) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one beat after a random gap; return at the falling edge after it is taken
    task automatic send_item(input logic op, input logic signed [VEL_W-1:0] lin,
                             input logic signed [VEL_W-1:0] ang);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        target_lin = lin;
        target_ang = ang;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic signed [VEL_W-1:0] draw_speed();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return VEL_W'($urandom_range(0, 8191) - 4096);
            default: return VEL_W'($urandom());
        endcase
    endfunction

    task automatic tick_burst(input int n);
        repeat (n) send_item(OP_TICK, draw_speed(), draw_speed());
    endtask

    // Drop valid and wait until every tick has reported and the block is quiet
    task automatic settle_idle();
        in_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup and access cycles; junk above the register's width must be ignored
    task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value,
                             input int width);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value | (DATA_W'($urandom()) << width);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setup(input cfg_t s);
        settle_idle();
        cfg_write(REG_MAX_LIN,       DATA_W'(s.max_lin),       LIM_W);
        cfg_write(REG_MAX_ANG,       DATA_W'(s.max_ang),       LIM_W);
        cfg_write(REG_WHEEL_SEP,     DATA_W'(s.wheel_sep),     SEP_W);
        cfg_write(REG_TIMEOUT_TICKS, DATA_W'(s.timeout_ticks), TICK_W);
        cfg_write(REG_LIN_STEP,      DATA_W'(s.lin_step),      LIM_W);
        cfg_write(REG_ANG_STEP,      DATA_W'(s.ang_step),      LIM_W);
        cfg_write(REG_LEFT_INVERT,   DATA_W'(s.left_invert),   1);
        cfg_write(REG_RIGHT_INVERT,  DATA_W'(s.right_invert),  1);
    endtask

    function automatic int pick_value(int hi, int usual);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return hi;
            2, 3:    return $urandom_range(0, hi);
            default: return $urandom_range(usual / 2, usual * 2);
        endcase
    endfunction

    function automatic cfg_t draw_setup();
        cfg_t s;
        s.max_lin   = LIM_W'(pick_value(32767, 1638));
        s.max_ang   = LIM_W'(pick_value(32767, 12288));
        s.wheel_sep = SEP_W'(pick_value(65535, 6554));
        s.lin_step  = LIM_W'(pick_value(32767, 82));
        s.ang_step  = LIM_W'(pick_value(32767, 492));
        case ($urandom_range(0, 5))
            0:       s.timeout_ticks = TICK_MAX;
            1:       s.timeout_ticks = '0;
            default: s.timeout_ticks = TICK_W'($urandom_range(1, 12));
        endcase
        s.left_invert  = 1'($urandom_range(0, 1));
        s.right_invert = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic random_items(input int n);
        logic op;
        repeat (n)
        begin
            op = ($urandom_range(0, 99) < COMMAND_PCT) ? OP_COMMAND : OP_TICK;
            send_item(op, draw_speed(), draw_speed());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        cfg_t setup;
        in_valid      = 1'b0;
        opcode        = OP_TICK;
        target_lin    = '0;
        target_ang    = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default limits: tick from rest, then slew toward both clamped extremes
        tick_burst(1);
        send_item(OP_COMMAND, 16'sh7FFF, 16'sh7FFF);
        tick_burst(4);
        send_item(OP_COMMAND, 16'sh8000, 16'sh8000);
        tick_burst(2);

        // Widest limits, both sides inverted, watchdog expiring on the second tick
        setup               = CFG_RESET;
        setup.max_lin       = '1;
        setup.max_ang       = '1;
        setup.wheel_sep     = '1;
        setup.timeout_ticks = TICK_W'(1);
        setup.lin_step      = '1;
        setup.ang_step      = '1;
        setup.left_invert   = 1'b1;
        setup.right_invert  = 1'b1;
        apply_setup(setup);
        send_item(OP_COMMAND, 16'sh7FFF, 16'sh8000);
        tick_burst(3);
        send_item(OP_COMMAND, 16'sh8000, 16'sh7FFF);
        tick_burst(1);

        // Zero scale and zero limits, watchdog disabled
        setup               = '0;
        setup.timeout_ticks = TICK_MAX;
        setup.left_invert   = 1'b1;
        apply_setup(setup);
        send_item(OP_COMMAND, VEL_W'(1234), -VEL_W'(1234));
        tick_burst(2);

        // Random settings; one phase holds the receiver off, one runs without gaps
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            apply_setup(draw_setup());
            sender_gaps   = (k != 2) && (k != 4);
            receiver_gaps = (k != 4);
            if (k == 2) hold_req = 1'b1;
            random_items(PHASE_ITEMS);
        end

        settle_idle();
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
